/* hdl/dtpc_pkg.sv */
// shared types and constants for the dna trie prefix counter
`timescale 1ns / 1ps
`default_nettype none

package dtpc_pkg;

  localparam int NODE_COUNT_DEF = 4096;
  localparam int COUNT_BITS_DEF = 20;

  localparam int SYMBOL_W       = 8;
  localparam int PREFIX_COUNT_W = 20;
  localparam logic [PREFIX_COUNT_W-1:0] PREFIX_COUNT_MAX = '1;

  // ascii codes of the four bases
  localparam logic [SYMBOL_W-1:0] CHAR_C = 8'h63;
  localparam logic [SYMBOL_W-1:0] CHAR_T = 8'h74;
  localparam logic [SYMBOL_W-1:0] CHAR_G = 8'h67;
  localparam logic [SYMBOL_W-1:0] CHAR_A = 8'h61;

  typedef enum logic [1:0] {
    BR_C = 2'd0,
    BR_T = 2'd1,
    BR_G = 2'd2,
    BR_A = 2'd3
  } branch_e;

  // one classified word from front to back
  typedef struct packed {
    branch_e branch;
    logic    bad;
    logic    last;
  } item_t;

  // status from back to front
  typedef struct packed {
    logic clearing;
  } back_stat_t;

endpackage

`default_nettype wire

/* hdl/dtpc_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module dtpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                        wdata_i,
  input  wire logic                                    re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hdl/dtpc_front.sv */
// front end: symbol classification and a two-entry word queue
`timescale 1ns / 1ps
`default_nettype none

module dtpc_front
  import dtpc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [SYMBOL_W-1:0] symbol_i,
  input  wire logic                last_symbol_i,
  output logic                     busy_o,
  input  wire back_stat_t          stat_i,
  output logic                     valid_o,
  output item_t                    item_o,
  input  wire logic                pop_i
);

  localparam int QueueDepth = 2;

  item_t       entries_q [QueueDepth];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q, count_d;
  item_t       cls;
  logic        push, full;

  // map the raw character to a branch
  always_comb begin
    cls.last   = last_symbol_i;
    cls.bad    = 1'b0;
    cls.branch = BR_C;
    unique case (symbol_i)
      CHAR_C:  cls.branch = BR_C;
      CHAR_T:  cls.branch = BR_T;
      CHAR_G:  cls.branch = BR_G;
      CHAR_A:  cls.branch = BR_A;
      default: cls.bad    = 1'b1;
    endcase
  end

  assign full    = (count_q == 2'(QueueDepth));
  assign busy_o  = full | stat_i.clearing;
  assign push    = start_i & ~busy_o;
  assign valid_o = (count_q != 2'd0);
  assign item_o  = entries_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push && pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= cls;
    end
  end

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != 2'd0)
    else $error("pop from empty queue");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'(QueueDepth))
    else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

/* hdl/dtpc_back.sv */
// back end: trie walk over child and count memories
`timescale 1ns / 1ps
`default_nettype none

module dtpc_back
  import dtpc_pkg::*;
#(
  parameter int NODE_COUNT = NODE_COUNT_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      valid_i,
  input  wire item_t                     item_i,
  output logic                           pop_o,
  output back_stat_t                     stat_o,
  output logic                           done_o,
  output logic [PREFIX_COUNT_W-1:0]      prefix_count_o,
  output logic                           pool_exhausted_o,
  output logic                           bad_symbol_o
);

  localparam int NodeW     = $clog2(NODE_COUNT);
  localparam int SlotDepth = NODE_COUNT * 4;
  localparam int SlotW     = NodeW + 2;
  localparam int CapW      = (COUNT_BITS > PREFIX_COUNT_W) ? COUNT_BITS : PREFIX_COUNT_W;
  localparam logic [SlotW-1:0]      SlotLast = SlotW'(SlotDepth - 1);
  localparam logic [NodeW:0]        PoolEnd  = (NodeW + 1)'(NODE_COUNT);
  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_CHILD = 4'b0100,
    ST_COUNT = 4'b1000
  } state_e;

  state_e                    state_q, state_d;
  logic [NodeW-1:0]          cursor_q, cursor_d;
  logic [NodeW:0]            next_free_q, next_free_d;
  logic                      err_pool_q, err_pool_d;
  logic                      err_sym_q, err_sym_d;
  logic [COUNT_BITS-1:0]     last_cnt_q, last_cnt_d;
  item_t                     item_q, item_d;
  logic [NodeW-1:0]          child_q, child_d;
  logic [SlotW-1:0]          clr_addr_q, clr_addr_d;
  logic                      res_valid_q, res_valid_d;
  logic [PREFIX_COUNT_W-1:0] res_count_q, res_count_d;
  logic                      res_pool_q, res_pool_d;
  logic                      res_sym_q, res_sym_d;

  logic                      child_we, child_re;
  logic [SlotW-1:0]          child_waddr, child_raddr;
  logic [NodeW-1:0]          child_wdata, child_rdata;
  logic                      count_we, count_re;
  logic [NodeW-1:0]          count_waddr, count_raddr;
  logic [COUNT_BITS-1:0]     count_wdata, count_rdata;

  logic                      finish, fin_last;
  logic [CapW-1:0]           cnt_wide;

  dtpc_ram #(
    .WIDTH (NodeW),
    .DEPTH (SlotDepth)
  ) u_child_ram (
    .clk_i   (clk_i),
    .we_i    (child_we),
    .waddr_i (child_waddr),
    .wdata_i (child_wdata),
    .re_i    (child_re),
    .raddr_i (child_raddr),
    .rdata_o (child_rdata)
  );

  dtpc_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (NODE_COUNT)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (count_we),
    .waddr_i (count_waddr),
    .wdata_i (count_wdata),
    .re_i    (count_re),
    .raddr_i (count_raddr),
    .rdata_o (count_rdata)
  );

  always_comb begin
    state_d     = state_q;
    cursor_d    = cursor_q;
    next_free_d = next_free_q;
    err_pool_d  = err_pool_q;
    err_sym_d   = err_sym_q;
    last_cnt_d  = last_cnt_q;
    item_d      = item_q;
    child_d     = child_q;
    clr_addr_d  = clr_addr_q;
    res_valid_d = 1'b0;
    res_count_d = res_count_q;
    res_pool_d  = res_pool_q;
    res_sym_d   = res_sym_q;
    pop_o       = 1'b0;
    child_we    = 1'b0;
    child_waddr = {cursor_q, item_q.branch};
    child_wdata = next_free_q[NodeW-1:0];
    child_re    = 1'b0;
    child_raddr = {cursor_q, item_i.branch};
    count_we    = 1'b0;
    count_waddr = next_free_q[NodeW-1:0];
    count_wdata = COUNT_BITS'(1);
    count_re    = 1'b0;
    count_raddr = child_rdata;
    finish      = 1'b0;
    fin_last    = item_q.last;
    cnt_wide    = '0;

    unique case (state_q)
      ST_CLEAR: begin
        child_we    = 1'b1;
        child_waddr = clr_addr_q;
        child_wdata = '0;
        clr_addr_d  = clr_addr_q + SlotW'(1);
        if (clr_addr_q == SlotLast) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        fin_last = item_i.last;
        if (valid_i) begin
          pop_o  = 1'b1;
          item_d = item_i;
          if (err_pool_q || err_sym_q) begin
            // walk already stopped for this string
            finish = 1'b1;
          end else if (item_i.bad) begin
            err_sym_d = 1'b1;
            finish    = 1'b1;
          end else begin
            child_re = 1'b1;
            state_d  = ST_CHILD;
          end
        end
      end
      ST_CHILD: begin
        if (child_rdata == '0) begin
          state_d = ST_IDLE;
          finish  = 1'b1;
          if (next_free_q == PoolEnd) begin
            err_pool_d = 1'b1;
          end else begin
            // new node: link it, count starts at one, read value is zero
            child_we    = 1'b1;
            count_we    = 1'b1;
            cursor_d    = next_free_q[NodeW-1:0];
            last_cnt_d  = '0;
            next_free_d = next_free_q + (NodeW + 1)'(1);
          end
        end else begin
          count_re = 1'b1;
          child_d  = child_rdata;
          state_d  = ST_COUNT;
        end
      end
      ST_COUNT: begin
        count_we    = 1'b1;
        count_waddr = child_q;
        count_wdata = (count_rdata == CountMax) ? count_rdata
                                                : count_rdata + COUNT_BITS'(1);
        last_cnt_d  = count_rdata;
        cursor_d    = child_q;
        finish      = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (finish && fin_last) begin
      cnt_wide    = CapW'(last_cnt_d);
      res_valid_d = 1'b1;
      res_pool_d  = err_pool_d;
      res_sym_d   = err_sym_d;
      if (err_pool_d || err_sym_d) begin
        res_count_d = '0;
      end else if (cnt_wide > CapW'(PREFIX_COUNT_MAX)) begin
        res_count_d = PREFIX_COUNT_MAX;
      end else begin
        res_count_d = cnt_wide[PREFIX_COUNT_W-1:0];
      end
      cursor_d   = '0;
      err_pool_d = 1'b0;
      err_sym_d  = 1'b0;
      last_cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cursor_q    <= '0;
      next_free_q <= (NodeW + 1)'(1);
      err_pool_q  <= 1'b0;
      err_sym_q   <= 1'b0;
      last_cnt_q  <= '0;
      clr_addr_q  <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      next_free_q <= next_free_d;
      err_pool_q  <= err_pool_d;
      err_sym_q   <= err_sym_d;
      last_cnt_q  <= last_cnt_d;
      clr_addr_q  <= clr_addr_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    child_q     <= child_d;
    res_count_q <= res_count_d;
    res_pool_q  <= res_pool_d;
    res_sym_q   <= res_sym_d;
  end

  assign stat_o.clearing  = (state_q == ST_CLEAR);
  assign done_o           = res_valid_q;
  assign prefix_count_o   = res_count_q;
  assign pool_exhausted_o = res_pool_q;
  assign bad_symbol_o     = res_sym_q;

`ifndef SYNTHESIS
  a_no_pop_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !pop_o)
    else $error("word taken during clearing pass");
  a_pool_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_free_q <= PoolEnd && next_free_q != '0)
    else $error("free node pointer out of range");
  a_alloc_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(next_free_q) |-> next_free_q == $past(next_free_q) + (NodeW + 1)'(1))
    else $error("free node pointer moved by more than one");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && (res_pool_q || res_sym_q)) |-> res_count_q == '0)
    else $error("error result with nonzero count");
`endif

endmodule

`default_nettype wire

/* hdl/dna_trie_prefix_counter.sv */
// top level of the dna trie prefix counter
// per character: a failed string or bad symbol ends in idle, a missing child is linked as a
//   new node after the child ram read, an existing node adds a count ram rmw after it
// result strobe is registered and comes in the cycle after the final character's walk step; the receiver cannot stall
// busy_o rises when the two-word queue is full, so the front keeps taking words while the walk runs
// after reset all 4 * NODE_COUNT child table slots are swept to zero, with busy_o high
`timescale 1ns / 1ps
`default_nettype none

module dna_trie_prefix_counter
  import dtpc_pkg::*;
#(
  parameter int NODE_COUNT = NODE_COUNT_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // input word: one character per accepted start
  input  wire logic                      start_i,
  output logic                           busy_o,
  input  wire logic [SYMBOL_W-1:0]       symbol_i,
  input  wire logic                      last_symbol_i,
  // result word: valid for exactly one cycle while done_o is high
  output logic                           done_o,
  output logic [PREFIX_COUNT_W-1:0]      prefix_count_o,
  output logic                           pool_exhausted_o,
  output logic                           bad_symbol_o
);

  // classified words queued between front and back
  item_t      item;
  logic       item_valid;
  logic       item_pop;
  back_stat_t back_stat;

  // front: decodes c,t,g,a into a branch, flags anything else, buffers words
  dtpc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .symbol_i      (symbol_i),
    .last_symbol_i (last_symbol_i),
    .busy_o        (busy_o),
    .stat_i        (back_stat),
    .valid_o       (item_valid),
    .item_o        (item),
    .pop_i         (item_pop)
  );

  // back: one trie step per word, node allocation, saturating counts, result register
  dtpc_back #(
    .NODE_COUNT (NODE_COUNT),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (item_valid),
    .item_i           (item),
    .pop_o            (item_pop),
    .stat_o           (back_stat),
    .done_o           (done_o),
    .prefix_count_o   (prefix_count_o),
    .pool_exhausted_o (pool_exhausted_o),
    .bad_symbol_o     (bad_symbol_o)
  );

endmodule

`default_nettype wire

/* tb/dna_trie_prefix_counter_tb.sv */
// self-checking testbench for the dna trie prefix counter
`timescale 1ns / 1ps

module dna_trie_prefix_counter_tb;
  import dtpc_pkg::*;

  localparam int NODE_COUNT = NODE_COUNT_DEF;
  localparam logic [COUNT_BITS_DEF-1:0] NODE_COUNT_MAX = '1;
  // the child table sweep after reset keeps busy high while all 4 * NODE_COUNT slots are cleared
  localparam int STALL_LIMIT = 12 * NODE_COUNT;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_WORDS = 1600;
  localparam int TAIL_WORDS = 160;
  // one long chain of a single base walks deep into the trie
  localparam int CHAIN_LEN = 100;
  localparam int HIST_DEPTH = 32;
  localparam int HIST_LEN = 16;

  // one character word waiting to be sent
  typedef struct packed {
    logic [SYMBOL_W-1:0] symbol;
    logic                last;
    logic                may_idle;
  } symbol_word_t;

  // one predicted result word
  typedef struct packed {
    logic [PREFIX_COUNT_W-1:0] count;
    logic                      pool_out;
    logic                      sym_bad;
  } prefix_result_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      start_i = 1'b0;
  logic [SYMBOL_W-1:0]       symbol_i = '0;
  logic                      last_symbol_i = 1'b0;
  logic                      busy_o;
  logic                      done_o;
  logic [PREFIX_COUNT_W-1:0] prefix_count_o;
  logic                      pool_exhausted_o;
  logic                      bad_symbol_o;

  dna_trie_prefix_counter dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .symbol_i         (symbol_i),
    .last_symbol_i    (last_symbol_i),
    .done_o           (done_o),
    .prefix_count_o   (prefix_count_o),
    .pool_exhausted_o (pool_exhausted_o),
    .bad_symbol_o     (bad_symbol_o)
  );

  // words still to be sent, front is the one on the ports
  symbol_word_t   symbol_queue[$];
  // counts the trie walk has produced but the block has not yet reported
  prefix_result_t due_results[$];

  // mirror of the trie
  bit [11:0]               trie_child [NODE_COUNT*4];
  bit [COUNT_BITS_DEF-1:0] trie_count [NODE_COUNT];
  logic [11:0]             walk_node = '0;
  logic [12:0]             free_node = 13'd1;
  logic                    walk_pool_fail = 1'b0;
  logic                    walk_sym_fail = 1'b0;
  logic [COUNT_BITS_DEF-1:0] walk_count = '0;

  // recent well-formed strings, reused so that prefix counts grow
  logic [SYMBOL_W-1:0] hist_chars [HIST_DEPTH][HIST_LEN];
  int                  hist_len [HIST_DEPTH];
  int                  hist_n = 0;
  int                  hist_next = 0;

  logic took_word = 1'b0;
  int   idle_left = 0;
  int   stall_cycles = 0;
  int   mismatch_count = 0;
  int   result_index = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  task automatic flag_mismatch(string msg);
    $display("mismatch at result %0d: %s", result_index, msg);
    mismatch_count++;
  endtask

  // map a raw character to its branch, 0 when it is not a base
  function automatic bit base_branch(logic [SYMBOL_W-1:0] sym, output branch_e br);
    br = BR_C;
    case (sym)
      CHAR_C: br = BR_C;
      CHAR_T: br = BR_T;
      CHAR_G: br = BR_G;
      CHAR_A: br = BR_A;
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // one step of the merged query and insert walk
  function automatic void trie_walk(logic [SYMBOL_W-1:0] sym);
    branch_e     br;
    logic [13:0] slot;
    logic [11:0] child;
    // a failed string ignores the rest of its characters
    if (walk_pool_fail || walk_sym_fail) return;
    if (!base_branch(sym, br)) begin
      walk_sym_fail = 1'b1;
      return;
    end
    slot = {walk_node, br};
    child = trie_child[slot];
    if (child == '0) begin
      // missing child: allocate from the pool or give up
      if (free_node >= NODE_COUNT) begin
        walk_pool_fail = 1'b1;
        return;
      end
      child = free_node[11:0];
      free_node++;
      trie_child[slot] = child;
      trie_count[child] = '0;
    end
    walk_node = child;
    walk_count = trie_count[child];
    if (trie_count[child] != NODE_COUNT_MAX) trie_count[child]++;
  endfunction

  function automatic logic [SYMBOL_W-1:0] pick_base();
    branch_e br;
    br = branch_e'($urandom_range(0, 3));
    case (br)
      BR_C: return CHAR_C;
      BR_T: return CHAR_T;
      BR_G: return CHAR_G;
      default: return CHAR_A;
    endcase
  endfunction

  function automatic logic [SYMBOL_W-1:0] pick_non_base();
    logic [SYMBOL_W-1:0] v;
    branch_e             br;
    do v = SYMBOL_W'($urandom_range(0, 255)); while (base_branch(v, br));
    return v;
  endfunction

  function automatic void push_word(logic [SYMBOL_W-1:0] sym, logic last, logic may_idle);
    symbol_word_t w;
    w.symbol = sym;
    w.last = last;
    w.may_idle = may_idle;
    symbol_queue.push_back(w);
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_word(s[i], i == s.len() - 1, 1'b1);
  endfunction

  // mostly well-formed strings, some with one bad character, some pure noise
  function automatic void push_random_string(logic may_idle);
    int                  kind, len, h;
    logic [SYMBOL_W-1:0] chars [HIST_LEN];
    kind = $urandom_range(0, 99);
    if (kind < 35 && hist_n > 0) begin
      // a prefix of an earlier string, sometimes one base longer
      h = $urandom_range(0, hist_n - 1);
      len = $urandom_range(1, hist_len[h]);
      for (int i = 0; i < len; i++) chars[i] = hist_chars[h][i];
      if (len < HIST_LEN && $urandom_range(0, 3) == 0) begin
        chars[len] = pick_base();
        len++;
      end
    end else begin
      len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 4) : $urandom_range(5, HIST_LEN);
      for (int i = 0; i < len; i++) chars[i] = pick_base();
    end
    if (kind >= 80 && kind < 92) begin
      chars[$urandom_range(0, len - 1)] = pick_non_base();
    end else if (kind >= 92) begin
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) chars[i] = SYMBOL_W'($urandom_range(0, 255));
    end else begin
      for (int i = 0; i < len; i++) hist_chars[hist_next][i] = chars[i];
      hist_len[hist_next] = len;
      hist_next = (hist_next + 1) % HIST_DEPTH;
      if (hist_n < HIST_DEPTH) hist_n++;
    end
    for (int i = 0; i < len; i++) push_word(chars[i], i == len - 1, may_idle);
  endfunction

  // driver: new values at the falling edge, words popped once taken
  always @(negedge clk_i) begin
    if (took_word) begin
      void'(symbol_queue.pop_front());
      // random idle burst before the next word, never in the tail
      if (symbol_queue.size() != 0 && symbol_queue[0].may_idle && $urandom_range(0, 7) == 0)
        idle_left = $urandom_range(1, 18);
    end
    if (!rst_ni || idle_left > 0 || symbol_queue.size() == 0) begin
      if (idle_left > 0) idle_left--;
      start_i <= 1'b0;
      // junk on the data ports while start is low
      symbol_i <= SYMBOL_W'($urandom_range(0, 255));
      last_symbol_i <= 1'($urandom_range(0, 1));
    end else begin
      start_i <= 1'b1;
      symbol_i <= symbol_queue[0].symbol;
      last_symbol_i <= symbol_queue[0].last;
    end
  end

  // monitor: predict on every accepted word, check every result strobe
  always @(posedge clk_i) begin
    prefix_result_t got, want;
    took_word = rst_ni && start_i && busy_o === 1'b0;
    if (took_word) begin
      trie_walk(symbol_i);
      if (last_symbol_i) begin
        want.count = (walk_pool_fail || walk_sym_fail) ? '0 : walk_count;
        want.pool_out = walk_pool_fail;
        want.sym_bad = walk_sym_fail;
        due_results.push_back(want);
        // the walk starts over at the root for the next string
        walk_node = '0;
        walk_pool_fail = 1'b0;
        walk_sym_fail = 1'b0;
        walk_count = '0;
      end
    end
    if (rst_ni && done_o !== 1'b0) begin
      got.count = prefix_count_o;
      got.pool_out = pool_exhausted_o;
      got.sym_bad = bad_symbol_o;
      if (due_results.size() == 0) begin
        flag_mismatch($sformatf("result with none due, count %0d", got.count));
      end else begin
        want = due_results.pop_front();
        if (got.count !== want.count)
          flag_mismatch($sformatf("prefix_count got %0d want %0d", got.count, want.count));
        if (got.pool_out !== want.pool_out)
          flag_mismatch($sformatf("pool_exhausted got %b want %b", got.pool_out,
                                  want.pool_out));
        if (got.sym_bad !== want.sym_bad)
          flag_mismatch($sformatf("bad_symbol got %b want %b", got.sym_bad, want.sym_bad));
      end
      result_index++;
    end
    // watchdog on cycles without any handshake
    if (took_word || (rst_ni && done_o === 1'b1)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", stall_cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int base_size;

    // directed: each base alone, c repeated, shared prefixes
    push_text("c");
    push_text("t");
    push_text("g");
    push_text("a");
    push_text("c");
    push_text("ca");
    push_text("cat");
    push_text("ca");
    // bad symbols at the extremes of the byte
    push_word(8'h00, 1'b1, 1'b1);
    push_word(8'hff, 1'b1, 1'b1);
    // bad symbol mid string, the leading c stays inserted
    push_word(CHAR_C, 1'b0, 1'b1);
    push_word(8'h43, 1'b0, 1'b1);
    push_word(CHAR_G, 1'b1, 1'b1);
    push_text("c");
    // bad symbol first, later bases ignored
    push_word(8'h20, 1'b0, 1'b1);
    push_word(CHAR_A, 1'b0, 1'b1);
    push_word(CHAR_T, 1'b1, 1'b1);
    push_text("tgca");
    push_text("tg");

    // random strings with idle bursts
    base_size = symbol_queue.size();
    while (symbol_queue.size() - base_size < RANDOM_WORDS) push_random_string(1'b1);

    // one deep chain of a single base
    for (int i = 0; i < CHAIN_LEN; i++) push_word(CHAR_G, i == CHAIN_LEN - 1, 1'b1);

    // tail without idling: old prefixes still hit
    base_size = symbol_queue.size();
    while (symbol_queue.size() - base_size < TAIL_WORDS) push_random_string(1'b0);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // all words taken and every result back
    do begin
      @(posedge clk_i);
      #1;
    end while (symbol_queue.size() != 0 || due_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    #1;

    if (mismatch_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

/* sim.f */
hdl/dtpc_pkg.sv
hdl/dtpc_ram.sv
hdl/dtpc_front.sv
hdl/dtpc_back.sv
hdl/dna_trie_prefix_counter.sv
tb/dna_trie_prefix_counter_tb.sv
